### rtl/core/jkpe_pkg.sv
package jkpe_pkg;

  localparam int unsigned KEY_BYTES = 8;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned WHOLE_W   = 31;
  localparam int unsigned FRAC_W    = 7;
  localparam int unsigned MAG_W     = 38;

  localparam logic [MAG_W-1:0] MAG_LIMIT = MAG_W'(32'h7FFF_FFFF);
  localparam logic [3:0]       SEEN_MAX  = 4'd15;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [0:0] {
    REG_KEY_LENGTH = 1'b0,
    REG_KEY_TEXT   = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_KEY   = 3'd0,
    PH_COLON = 3'd1,
    PH_SPACE = 3'd2,
    PH_SIGN  = 3'd3,
    PH_WHOLE = 3'd4,
    PH_FRAC  = 3'd5,
    PH_DONE  = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_KEY   = 2'd1,
    ST_NO_COLON = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    status_e              code;
    logic                 neg;
    logic                 too_large;
    logic [WHOLE_W-1:0]   whole;
    logic [FRAC_W-1:0]    frac;
  } raw_res_t;

endpackage

### rtl/core/json_key_price_extractor.sv
// Key/price extractor for a byte-serial text body.
// Input channel (in_valid_i/in_ready_o): one body byte per word, with
// end_of_body_i marking the last byte; a zero byte also ends the body.
// Output channel (out_valid_o/out_ready_i): one word per body, carrying
// price_hundredths_o (signed, value times 100) and status_o
// (0 ok, 1 key missing, 2 colon missing, 3 overflow).
// Config channel (cfg_valid_i/cfg_ready_o): index 0 key_length, index 1
// key_text; always ready. The user writes them only while the block is idle;
// the block itself does not enforce this. Throughput: one byte per cycle while
// in_ready_o is high. The key window is a row of eight byte cells shifting once
// per byte during the key search; parsing updates the accumulators in the same
// cycle. Three result stages (capture, multiply by 100, range check/negate)
// carry the result word of the ending byte, in that order, to out_valid_o.
// The three result stages drain independently, so bytes keep flowing while
// a result waits; in_ready_o drops only when all three stages are full.
// Reset: key_length 3, key_text 0x226323, window and parse state cleared,
// no result pending.
module json_key_price_extractor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         body_byte_i,
  input  logic               end_of_body_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] price_hundredths_o,
  output logic [1:0]         status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  logic [jkpe_pkg::LEN_W-1:0]      key_length_q;
  logic [63:0]                     key_text_q;
  logic [jkpe_pkg::LEN_W-1:0]      used_len;
  logic                            take;
  logic                            emit;
  logic                            res_free;
  logic                            win_match;
  logic [jkpe_pkg::KEY_BYTES-1:0]  cell_match;
  logic [7:0]                      cell_byte [jkpe_pkg::KEY_BYTES];
  jkpe_pkg::cell_ctrl_t            cell_ctrl;
  jkpe_pkg::raw_res_t              raw;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = res_free;
  assign take        = in_valid_i && res_free;
  assign used_len    = (key_length_q > jkpe_pkg::LEN_W'(jkpe_pkg::KEY_BYTES))
                     ? jkpe_pkg::LEN_W'(jkpe_pkg::KEY_BYTES) : key_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= jkpe_pkg::LEN_W'(3);
      key_text_q   <= 64'h0000_0000_0022_6323;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        jkpe_pkg::REG_KEY_LENGTH: key_length_q <= cfg_data_i[jkpe_pkg::LEN_W-1:0];
        jkpe_pkg::REG_KEY_TEXT:   key_text_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < jkpe_pkg::KEY_BYTES; k++) begin : g_cell
    if (k == 0) begin : g_head
      jkpe_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (cell_ctrl),
        .byte_i     (body_byte_i),
        .key_byte_i (key_text_q[8*k +: 8]),
        .byte_o     (cell_byte[k]),
        .match_o    (cell_match[k])
      );
    end else begin : g_body
      jkpe_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (cell_ctrl),
        .byte_i     (cell_byte[k-1]),
        .key_byte_i (key_text_q[8*k +: 8]),
        .byte_o     (cell_byte[k]),
        .match_o    (cell_match[k])
      );
    end
  end

  always_comb begin
    win_match = 1'b1;
    for (int k = 0; k < jkpe_pkg::KEY_BYTES; k++) begin
      if (jkpe_pkg::LEN_W'(k) < used_len) begin
        win_match = win_match && cell_match[k];
      end
    end
  end

  jkpe_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .byte_i      (body_byte_i),
    .last_i      (end_of_body_i),
    .used_len_i  (used_len),
    .win_match_i (win_match),
    .cell_ctrl_o (cell_ctrl),
    .emit_o      (emit),
    .raw_o       (raw)
  );

  jkpe_result u_result (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .emit_i             (emit),
    .raw_i              (raw),
    .free_o             (res_free),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .price_hundredths_o (price_hundredths_o),
    .status_o           (status_o)
  );

endmodule

### rtl/core/jkpe_cell.sv
module jkpe_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  jkpe_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]          byte_i,
  input  logic [7:0]          key_byte_i,
  output logic [7:0]          byte_o,
  output logic                match_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;

  // match is taken on the incoming byte, i.e. the window after the shift
  assign match_o = (byte_i == key_byte_i);
  assign byte_o  = byte_q;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.clear) begin
      byte_d = 8'd0;
    end else if (ctrl_i.shift) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'd0;
    end else begin
      byte_q <= byte_d;
    end
  end

endmodule

### rtl/core/jkpe_parse.sv
module jkpe_parse (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 take_i,
  input  logic [7:0]                           byte_i,
  input  logic                                 last_i,
  input  logic [jkpe_pkg::LEN_W-1:0]           used_len_i,
  input  logic                                 win_match_i,
  output jkpe_pkg::cell_ctrl_t                 cell_ctrl_o,
  output logic                                 emit_o,
  output jkpe_pkg::raw_res_t                   raw_o
);

  jkpe_pkg::phase_e               phase_q, phase_d, ph;
  logic [3:0]                     seen_q, seen_d;
  logic                           neg_q, neg_d, neg_n;
  logic [jkpe_pkg::WHOLE_W-1:0]   whole_q, whole_d, whole_n;
  logic [jkpe_pkg::FRAC_W-1:0]    fv_q, fv_d, fv_n;
  logic [1:0]                     fd_q, fd_d, fd_n;
  logic                           tl_q, tl_d, tl_n;
  logic                           run;
  logic                           digit;
  logic [34:0]                    whole_x10;
  logic [9:0]                     frac_x10;
  logic [jkpe_pkg::FRAC_W-1:0]    frac_adj;

  assign digit     = (byte_i >= jkpe_pkg::CH_ZERO) && (byte_i <= jkpe_pkg::CH_NINE);
  assign whole_x10 = {1'b0, whole_q, 3'b000} + {3'b000, whole_q, 1'b0} + 35'(byte_i[3:0]);
  assign frac_x10  = {fv_q, 3'b000} + {2'b00, fv_q, 1'b0} + 10'(byte_i[3:0]);

  always_comb begin
    ph          = phase_q;
    seen_d      = seen_q;
    neg_n       = neg_q;
    whole_n     = whole_q;
    fv_n        = fv_q;
    fd_n        = fd_q;
    tl_n        = tl_q;
    run         = 1'b1;
    cell_ctrl_o = '0;
    emit_o      = 1'b0;
    if (take_i) begin
      if (byte_i != jkpe_pkg::CH_NUL) begin
        if (ph == jkpe_pkg::PH_KEY) begin
          cell_ctrl_o.shift = 1'b1;
          if (seen_q != jkpe_pkg::SEEN_MAX) begin
            seen_d = seen_q + 4'd1;
          end
          if (used_len_i != '0) begin
            run = 1'b0;
            if ((seen_d >= used_len_i) && win_match_i) begin
              ph = jkpe_pkg::PH_COLON;
            end
          end else begin
            ph = jkpe_pkg::PH_COLON;
          end
        end
        if (run && ph == jkpe_pkg::PH_COLON) begin
          run = 1'b0;
          if (byte_i == jkpe_pkg::CH_COLON) begin
            ph = jkpe_pkg::PH_SPACE;
          end
        end
        if (run && ph == jkpe_pkg::PH_SPACE) begin
          if (byte_i == jkpe_pkg::CH_SPACE) begin
            run = 1'b0;
          end else begin
            ph = jkpe_pkg::PH_SIGN;
          end
        end
        if (run && ph == jkpe_pkg::PH_SIGN) begin
          ph = jkpe_pkg::PH_WHOLE;
          if (byte_i == jkpe_pkg::CH_MINUS) begin
            neg_n = 1'b1;
            run   = 1'b0;
          end
        end
        if (run && ph == jkpe_pkg::PH_WHOLE) begin
          run = 1'b0;
          if (digit) begin
            if (whole_x10 > 35'(jkpe_pkg::MAG_LIMIT)) begin
              tl_n    = 1'b1;
              whole_n = '1;
            end else begin
              whole_n = whole_x10[jkpe_pkg::WHOLE_W-1:0];
            end
          end else if (byte_i == jkpe_pkg::CH_DOT) begin
            ph = jkpe_pkg::PH_FRAC;
          end else begin
            ph = jkpe_pkg::PH_DONE;
          end
        end
        if (run && ph == jkpe_pkg::PH_FRAC) begin
          run = 1'b0;
          if (digit) begin
            if (fd_q < 2'd2) begin
              fv_n = frac_x10[jkpe_pkg::FRAC_W-1:0];
              fd_n = fd_q + 2'd1;
            end
          end else begin
            ph = jkpe_pkg::PH_DONE;
          end
        end
      end else if (ph == jkpe_pkg::PH_KEY && used_len_i == '0) begin
        ph = jkpe_pkg::PH_COLON;
      end
      emit_o = (byte_i == jkpe_pkg::CH_NUL) || last_i;
    end
    cell_ctrl_o.clear = emit_o;
  end

  // a single fraction digit counts as tenths
  assign frac_adj = (fd_n == 2'd1) ? 7'({fv_n, 3'b000} + {2'b00, fv_n, 1'b0}) : fv_n;

  always_comb begin
    raw_o.neg       = neg_n;
    raw_o.too_large = tl_n;
    raw_o.whole     = whole_n;
    raw_o.frac      = frac_adj;
    if (ph == jkpe_pkg::PH_KEY) begin
      raw_o.code = jkpe_pkg::ST_NO_KEY;
    end else if (ph == jkpe_pkg::PH_COLON) begin
      raw_o.code = jkpe_pkg::ST_NO_COLON;
    end else begin
      raw_o.code = jkpe_pkg::ST_OK;
    end
  end

  always_comb begin
    if (emit_o) begin
      phase_d = jkpe_pkg::PH_KEY;
      neg_d   = 1'b0;
      whole_d = '0;
      fv_d    = '0;
      fd_d    = '0;
      tl_d    = 1'b0;
    end else begin
      phase_d = ph;
      neg_d   = neg_n;
      whole_d = whole_n;
      fv_d    = fv_n;
      fd_d    = fd_n;
      tl_d    = tl_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= jkpe_pkg::PH_KEY;
      seen_q  <= '0;
      neg_q   <= 1'b0;
      whole_q <= '0;
      fv_q    <= '0;
      fd_q    <= '0;
      tl_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      seen_q  <= emit_o ? 4'd0 : seen_d;
      neg_q   <= neg_d;
      whole_q <= whole_d;
      fv_q    <= fv_d;
      fd_q    <= fd_d;
      tl_q    <= tl_d;
    end
  end

endmodule

### rtl/core/jkpe_result.sv
module jkpe_result (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                emit_i,
  input  jkpe_pkg::raw_res_t  raw_i,
  output logic                free_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic signed [31:0]  price_hundredths_o,
  output logic [1:0]          status_o
);

  logic                          s1_v_q, s2_v_q, s3_v_q;
  logic                          s1_free, s2_free, s3_free;
  jkpe_pkg::raw_res_t            s1_q;
  jkpe_pkg::status_e             s2_code_q;
  logic                          s2_neg_q, s2_tl_q;
  logic [jkpe_pkg::MAG_W-1:0]    s2_mag_q, s2_mag_d;
  logic [31:0]                   s3_val_q, s3_val_d;
  jkpe_pkg::status_e             s3_st_q, s3_st_d;

  assign s3_free = !s3_v_q || out_ready_i;
  assign s2_free = !s2_v_q || s3_free;
  assign s1_free = !s1_v_q || s2_free;
  assign free_o  = s1_free;

  assign s2_mag_d = (jkpe_pkg::MAG_W'(s1_q.whole) * jkpe_pkg::MAG_W'(7'd100))
                  + jkpe_pkg::MAG_W'(s1_q.frac);

  always_comb begin
    s3_val_d = 32'd0;
    s3_st_d  = s2_code_q;
    if (s2_code_q == jkpe_pkg::ST_OK) begin
      if (s2_tl_q || (s2_mag_q > jkpe_pkg::MAG_LIMIT)) begin
        s3_st_d = jkpe_pkg::ST_OVERFLOW;
      end else if (s2_neg_q) begin
        s3_val_d = 32'd0 - s2_mag_q[31:0];
      end else begin
        s3_val_d = s2_mag_q[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_q <= emit_i;
      end
      if (s2_free) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_free) begin
        s3_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free) begin
      s1_q <= raw_i;
    end
    if (s2_free) begin
      s2_code_q <= s1_q.code;
      s2_neg_q  <= s1_q.neg;
      s2_tl_q   <= s1_q.too_large;
      s2_mag_q  <= s2_mag_d;
    end
    if (s3_free) begin
      s3_val_q <= s3_val_d;
      s3_st_q  <= s3_st_d;
    end
  end

  assign out_valid_o        = s3_v_q;
  assign price_hundredths_o = s3_val_q;
  assign status_o           = s3_st_q;

endmodule
